### hdl/lrz_pkg.sv
// Shared types, register map, operation codes and reset values of the Lorenz stepper.
`default_nettype none

package lrz_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int DATA_W        = 32;
    localparam int DT_W          = 31;
    localparam int ADDR_W        = 5;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_SIGMA   = 3'd0;
    localparam logic [2:0] REG_RHO     = 3'd1;
    localparam logic [2:0] REG_BETA    = 3'd2;
    localparam logic [2:0] REG_DT      = 3'd3;
    localparam logic [2:0] REG_START_X = 3'd4;
    localparam logic [2:0] REG_START_Y = 3'd5;
    localparam logic [2:0] REG_START_Z = 3'd6;

    localparam logic signed [DATA_W-1:0] SIGMA_RST = 32'sd167772160;
    localparam logic signed [DATA_W-1:0] RHO_RST   = 32'sd469762048;
    localparam logic signed [DATA_W-1:0] BETA_RST  = 32'sd44795167;
    localparam logic [DT_W-1:0]          DT_RST    = 31'd167772;
    localparam logic signed [DATA_W-1:0] START_RST = 32'sd1677722;

    // Item actions.
    localparam logic [1:0] ACT_STEP    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Shared unit operations.
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] sigma_gain;
        logic signed [DATA_W-1:0] rho_gain;
        logic signed [DATA_W-1:0] beta_gain;
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] start_x;
        logic signed [DATA_W-1:0] start_y;
        logic signed [DATA_W-1:0] start_z;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] opa;
        logic signed [DATA_W-1:0] opb;
    } alu_req_t;

endpackage

`default_nettype wire

### hdl/lrz_if.sv
// Handshake interfaces for the command and result channels.
`default_nettype none

interface lrz_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] load_x;
    logic [31:0] load_y;
    logic [31:0] load_z;

    modport source (output valid, action, load_x, load_y, load_z, input ready);
    modport sink   (input valid, action, load_x, load_y, load_z, output ready);
endinterface

interface lrz_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

### hdl/lrz_regs.sv
// APB configuration registers of the Lorenz stepper.
`default_nettype none

module lrz_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [lrz_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output lrz_pkg::cfg_t                  cfg
);
    import lrz_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma_gain <= SIGMA_RST;
            cfg_reg.rho_gain   <= RHO_RST;
            cfg_reg.beta_gain  <= BETA_RST;
            cfg_reg.time_step  <= DT_RST;
            cfg_reg.start_x    <= START_RST;
            cfg_reg.start_y    <= START_RST;
            cfg_reg.start_z    <= START_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_SIGMA:   cfg_reg.sigma_gain <= pwdata;
                REG_RHO:     cfg_reg.rho_gain   <= pwdata;
                REG_BETA:    cfg_reg.beta_gain  <= pwdata;
                REG_DT:      cfg_reg.time_step  <= pwdata[DT_W-1:0];
                REG_START_X: cfg_reg.start_x    <= pwdata;
                REG_START_Y: cfg_reg.start_y    <= pwdata;
                REG_START_Z: cfg_reg.start_z    <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SIGMA:   prdata = cfg_reg.sigma_gain;
            REG_RHO:     prdata = cfg_reg.rho_gain;
            REG_BETA:    prdata = cfg_reg.beta_gain;
            REG_DT:      prdata = {1'b0, cfg_reg.time_step};
            REG_START_X: prdata = cfg_reg.start_x;
            REG_START_Y: prdata = cfg_reg.start_y;
            REG_START_Z: prdata = cfg_reg.start_z;
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/lrz_alu.sv
// Shared arithmetic unit: saturating add, subtract and fixed-point multiply.
`default_nettype none

module lrz_alu #(
    parameter int FRAC_BITS = lrz_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             issue,
    input  wire lrz_pkg::alu_req_t                req,
    output logic signed [lrz_pkg::DATA_W-1:0]     result,
    output logic                                  clip
);
    import lrz_pkg::*;

    localparam int RAW_W = 2 * DATA_W;

    logic signed [RAW_W-1:0] raw_reg;
    logic signed [RAW_W-1:0] raw_next;
    logic                    is_mul_reg;
    logic signed [RAW_W-1:0] shifted;
    logic                    fits;

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: raw_next = RAW_W'($signed(req.opa)) + RAW_W'($signed(req.opb));
            ALU_SUB: raw_next = RAW_W'($signed(req.opa)) - RAW_W'($signed(req.opb));
            ALU_MUL: raw_next = $signed(req.opa) * $signed(req.opb);
            default: raw_next = '0;
        endcase
    end

    // The product is registered before the scaling shift and the clamp.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            raw_reg    <= raw_next;
            is_mul_reg <= (req.op == ALU_MUL);
        end
    end

    // An arithmetic right shift floors, which is the required rounding.
    assign shifted = is_mul_reg ? (raw_reg >>> FRAC_BITS) : raw_reg;
    assign fits    = (&shifted[RAW_W-1:DATA_W-1]) || !(|shifted[RAW_W-1:DATA_W-1]);
    assign clip    = !fits;

    always_comb
    begin
        if (fits)
            result = shifted[DATA_W-1:0];
        else if (shifted[RAW_W-1])
            result = {1'b1, {(DATA_W-1){1'b0}}};
        else
            result = {1'b0, {(DATA_W-1){1'b1}}};
    end

endmodule

`default_nettype wire

### hdl/lorenz_euler_stepper.sv
// Lorenz attractor stepper: forward Euler integration on one shared arithmetic unit.
// A step item's result is offered after fifteen operations on the shared unit, each with
// an issue and a write-back state, and a hand-over state; a new item is accepted only
// back in idle. Load and restart items set the point at acceptance. One item is in
// work at a time; a waiting result only holds the next step in its hand-over cycle.
// Reset (rst_n, asynchronous) sets the registers and the point to their defaults.
`default_nettype none

module lorenz_euler_stepper #(
    parameter int FRAC_BITS = lrz_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lrz_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    lrz_cmd_if.sink                         cmd,
    lrz_res_if.source                       res
);
    import lrz_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WB     = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [3:0] STEP_YX    = 4'd0;
    localparam logic [3:0] STEP_AX    = 4'd1;
    localparam logic [3:0] STEP_DX    = 4'd2;
    localparam logic [3:0] STEP_XR    = 4'd3;
    localparam logic [3:0] STEP_XRY   = 4'd4;
    localparam logic [3:0] STEP_XZ    = 4'd5;
    localparam logic [3:0] STEP_YSUM  = 4'd6;
    localparam logic [3:0] STEP_DY    = 4'd7;
    localparam logic [3:0] STEP_XY    = 4'd8;
    localparam logic [3:0] STEP_ZC    = 4'd9;
    localparam logic [3:0] STEP_ZSUM  = 4'd10;
    localparam logic [3:0] STEP_DZ    = 4'd11;
    localparam logic [3:0] STEP_NEWX  = 4'd12;
    localparam logic [3:0] STEP_NEWY  = 4'd13;
    localparam logic [3:0] STEP_NEWZ  = 4'd14;

    cfg_t                     cfg;
    alu_req_t                 alu_req;
    logic                     alu_issue;
    logic signed [DATA_W-1:0] alu_result;
    logic                     alu_clip;
    logic signed [DATA_W-1:0] dt_op;

    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       clip_reg, clip_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       hand_over;

    logic signed [DATA_W-1:0] x_reg, y_reg, z_reg;
    logic signed [DATA_W-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [DATA_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [DATA_W-1:0]        out_x_reg, out_y_reg, out_z_reg;
    logic                     out_sat_reg;

    lrz_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrz_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .issue  (alu_issue),
        .req    (alu_req),
        .result (alu_result),
        .clip   (alu_clip)
    );

    assign cmd.ready     = (state_reg == ST_IDLE);
    assign accept        = cmd.valid && cmd.ready;
    assign hand_over     = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);
    assign alu_issue     = (state_reg == ST_ISSUE);
    assign dt_op         = {1'b0, cfg.time_step};

    assign res.valid     = out_valid_reg;
    assign res.out_x     = out_x_reg;
    assign res.out_y     = out_y_reg;
    assign res.out_z     = out_z_reg;
    assign res.saturated = out_sat_reg;

    // Operation schedule of one Euler step.
    always_comb
    begin
        alu_req.op  = ALU_MUL;
        alu_req.opa = x_reg;
        alu_req.opb = y_reg;
        unique case (step_reg)
            STEP_YX:   begin alu_req.op = ALU_SUB; alu_req.opa = y_reg;  alu_req.opb = x_reg;  end
            STEP_AX:   begin alu_req.opa = cfg.sigma_gain; alu_req.opb = t0_reg; end
            STEP_DX:   begin alu_req.opa = t0_reg; alu_req.opb = dt_op;  end
            STEP_XR:   begin alu_req.opa = x_reg;  alu_req.opb = cfg.rho_gain; end
            STEP_XRY:  begin alu_req.op = ALU_SUB; alu_req.opa = t1_reg; alu_req.opb = y_reg;  end
            STEP_XZ:   begin alu_req.opa = x_reg;  alu_req.opb = z_reg;  end
            STEP_YSUM: begin alu_req.op = ALU_SUB; alu_req.opa = t1_reg; alu_req.opb = t2_reg; end
            STEP_DY:   begin alu_req.opa = t1_reg; alu_req.opb = dt_op;  end
            STEP_XY:   begin alu_req.opa = x_reg;  alu_req.opb = y_reg;  end
            STEP_ZC:   begin alu_req.opa = z_reg;  alu_req.opb = cfg.beta_gain; end
            STEP_ZSUM: begin alu_req.op = ALU_SUB; alu_req.opa = t1_reg; alu_req.opb = t2_reg; end
            STEP_DZ:   begin alu_req.opa = t1_reg; alu_req.opb = dt_op;  end
            STEP_NEWX: begin alu_req.op = ALU_ADD; alu_req.opa = x_reg;  alu_req.opb = dx_reg; end
            STEP_NEWY: begin alu_req.op = ALU_ADD; alu_req.opa = y_reg;  alu_req.opb = dy_reg; end
            STEP_NEWZ: begin alu_req.op = ALU_ADD; alu_req.opa = z_reg;  alu_req.opb = dz_reg; end
            default:   ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !res.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.action == ACT_STEP)
                begin
                    state_next = ST_ISSUE;
                    step_next  = STEP_YX;
                    clip_next  = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                clip_next = clip_reg || alu_clip;
                if (step_reg == STEP_NEWZ)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ISSUE;
                    step_next  = step_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                if (hand_over)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_YX;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= START_RST;
            y_reg         <= START_RST;
            z_reg         <= START_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
            if (accept && cmd.action == ACT_LOAD)
            begin
                x_reg <= cmd.load_x;
                y_reg <= cmd.load_y;
                z_reg <= cmd.load_z;
            end
            else if (accept && cmd.action == ACT_RESTART)
            begin
                x_reg <= cfg.start_x;
                y_reg <= cfg.start_y;
                z_reg <= cfg.start_z;
            end
            else if (hand_over)
            begin
                x_reg <= dx_reg;
                y_reg <= dy_reg;
                z_reg <= dz_reg;
            end
        end
    end

    // Write back of the shared unit; the point itself changes only at hand-over or on a load or restart item.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WB)
        begin
            case (step_reg)
                STEP_YX, STEP_AX:                      t0_reg <= alu_result;
                STEP_XR, STEP_XRY, STEP_YSUM, STEP_XY,
                STEP_ZSUM:                             t1_reg <= alu_result;
                STEP_XZ, STEP_ZC:                      t2_reg <= alu_result;
                STEP_DX, STEP_NEWX:                    dx_reg <= alu_result;
                STEP_DY, STEP_NEWY:                    dy_reg <= alu_result;
                STEP_DZ, STEP_NEWZ:                    dz_reg <= alu_result;
                default:                               ;
            endcase
        end
        if (hand_over)
        begin
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            out_z_reg   <= z_reg;
            out_sat_reg <= clip_reg;
        end
    end

endmodule

`default_nettype wire

### tb/tb_lorenz_euler_stepper.sv
// Self-checking testbench of the Lorenz Euler stepper: APB setup, directed and random items.
module tb_lorenz_euler_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    import lrz_pkg::*;

    localparam int          FRAC          = FRAC_BITS_DEF;
    localparam logic [2:0]  REG_NONE      = 3'd7;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          PHASE_ITEMS   = 64;
    localparam int          PHASE_COUNT   = 6;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          REPORT_CAP    = 40;
    localparam longint      S32_MAX       = 64'sd2147483647;
    localparam longint      S32_MIN       = -64'sd2147483648;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } point_result_t;

    // Tracks the point and the register file, and holds the points that steps must return.
    class lorenz_tracker;
        cfg_t               cfg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        bit                 clipped;
        point_result_t      expected[$];
        int                 commands;
        int                 checked;
        int                 clip_steps;
        int                 errors;

        function new();
            cfg.sigma_gain = SIGMA_RST;
            cfg.rho_gain   = RHO_RST;
            cfg.beta_gain  = BETA_RST;
            cfg.time_step  = DT_RST;
            cfg.start_x    = START_RST;
            cfg.start_y    = START_RST;
            cfg.start_z    = START_RST;
            px = START_RST;
            py = START_RST;
            pz = START_RST;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SIGMA:   cfg.sigma_gain = value;
                REG_RHO:     cfg.rho_gain   = value;
                REG_BETA:    cfg.beta_gain  = value;
                REG_DT:      cfg.time_step  = value[DT_W-1:0];
                REG_START_X: cfg.start_x    = value;
                REG_START_Y: cfg.start_y    = value;
                REG_START_Z: cfg.start_z    = value;
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > S32_MAX) begin
                clipped = 1'b1;
                return S32_MAX;
            end
            if (v < S32_MIN) begin
                clipped = 1'b1;
                return S32_MIN;
            end
            return v;
        endfunction

        // Exact product, floored by the arithmetic shift, then clamped.
        function longint qmul(longint p, longint q);
            longint prod;
            prod = p * q;
            return sat32(prod >>> FRAC);
        endfunction

        function void euler_advance();
            longint x, y, z, ga, gr, gc, dt, dx, dy, dz;
            x  = longint'(px);
            y  = longint'(py);
            z  = longint'(pz);
            ga = longint'($signed(cfg.sigma_gain));
            gr = longint'($signed(cfg.rho_gain));
            gc = longint'($signed(cfg.beta_gain));
            dt = longint'({1'b0, cfg.time_step});
            dx = qmul(qmul(ga, sat32(y - x)), dt);
            dy = qmul(sat32(sat32(qmul(x, gr) - y) - qmul(x, z)), dt);
            dz = qmul(sat32(qmul(x, y) - qmul(z, gc)), dt);
            px = 32'(sat32(x + dx));
            py = 32'(sat32(y + dy));
            pz = 32'(sat32(z + dz));
        endfunction

        function void take_command(logic [1:0] action, logic [31:0] lx, logic [31:0] ly,
                                   logic [31:0] lz);
            point_result_t r;
            commands++;
            case (action)
                ACT_LOAD: begin
                    px = lx;
                    py = ly;
                    pz = lz;
                end
                ACT_RESTART: begin
                    px = cfg.start_x;
                    py = cfg.start_y;
                    pz = cfg.start_z;
                end
                ACT_STEP: begin
                    r.x = px;
                    r.y = py;
                    r.z = pz;
                    clipped = 1'b0;
                    euler_advance();
                    r.sat = clipped;
                    if (clipped)
                        clip_steps++;
                    expected.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_point(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                  logic osat);
            point_result_t want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: result with no step waiting, actual x %h y %h z %h sat %b",
                         $time, ox, oy, oz, osat);
                return;
            end
            want = expected.pop_front();
            checked++;
            report_field("out_x", want.x, ox);
            report_field("out_y", want.y, oy);
            report_field("out_z", want.z, oz);
            report_field("saturated", {31'd0, want.sat}, {31'd0, osat});
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    wire  [31:0]       prdata;
    wire               pready;
    int                idle_pct = 16;
    int unsigned       cycle_count = 0;
    lorenz_tracker     tracker;

    lrz_cmd_if cmd_ch();
    lrz_res_if res_ch();

    lorenz_euler_stepper u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .res     (res_ch)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
            tracker.check_point(res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.saturated);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d steps still outstanding",
                 cycle_count, tracker.expected.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Coefficient drawn between lo and hi in whole units.
    function automatic logic [31:0] coef_q(int unsigned lo, int unsigned hi);
        return $urandom_range(lo << FRAC, hi << FRAC);
    endfunction

    // Coordinate within +/-50.0, the range the attractor lives in.
    function automatic logic [31:0] small_q();
        return $urandom_range(0, 32'd1677721600) - 32'd838860800;
    endfunction

    function automatic logic [31:0] load_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return $urandom;
        if (pick < 90)
            return small_q();
        case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'd0;
            3: return 32'd1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_cmd(logic [1:0] action, logic [31:0] lx, logic [31:0] ly,
                            logic [31:0] lz);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= action;
        cmd_ch.load_x <= lx;
        cmd_ch.load_y <= ly;
        cmd_ch.load_z <= lz;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.take_command(action, lx, ly, lz);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    // Drain every outstanding step, then give a trailing load or restart time to finish.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (tracker.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int          done = 0;
        int unsigned pick;
        logic [1:0]  act;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 70)
                act = ACT_STEP;
            else if (pick < 82)
                act = ACT_LOAD;
            else if (pick < 92)
                act = ACT_RESTART;
            else
                act = ACT_UNUSED;
            send_cmd(act, load_value(), load_value(), load_value());
            if (act != ACT_UNUSED)
                done++;
        end
    endtask

    task automatic program_phase(int phase);
        case (phase)
            1: begin
                write_register(REG_SIGMA, coef_q(5, 15));
                write_register(REG_RHO, coef_q(10, 40));
                write_register(REG_BETA, coef_q(1, 4));
                write_register(REG_DT, $urandom_range(1 << 14, 1 << 19));
                write_register(REG_START_X, small_q());
                write_register(REG_START_Y, small_q());
                write_register(REG_START_Z, small_q());
                write_register(REG_NONE, $urandom);
            end
            2: begin
                write_register(REG_SIGMA, Q_MAX);
                write_register(REG_RHO, Q_MIN);
                write_register(REG_BETA, Q_MAX);
                // Top bit lies outside the step register and must be dropped.
                write_register(REG_DT, 32'hFFFF_FFFF);
                write_register(REG_START_X, Q_MAX);
                write_register(REG_START_Y, Q_MIN);
                write_register(REG_START_Z, Q_MAX);
            end
            3: begin
                write_register(REG_SIGMA, 32'd0);
                write_register(REG_RHO, 32'd0);
                write_register(REG_BETA, 32'd0);
                write_register(REG_DT, 32'd0);
                write_register(REG_START_X, Q_MIN);
                write_register(REG_START_Y, Q_MAX);
                write_register(REG_START_Z, 32'd0);
            end
            4: begin
                write_register(REG_SIGMA, $urandom);
                write_register(REG_RHO, $urandom);
                write_register(REG_BETA, $urandom);
                write_register(REG_DT, $urandom);
                write_register(REG_START_X, $urandom);
                write_register(REG_START_Y, $urandom);
                write_register(REG_START_Z, $urandom);
                write_register(REG_NONE, $urandom);
            end
            default: begin
                write_register(REG_SIGMA, SIGMA_RST);
                write_register(REG_RHO, RHO_RST);
                write_register(REG_BETA, BETA_RST);
                write_register(REG_DT, {1'b0, DT_RST});
                write_register(REG_START_X, small_q());
                write_register(REG_START_Y, small_q());
                write_register(REG_START_Z, small_q());
            end
        endcase
    endtask

    initial
    begin : stimulus
        tracker = new();
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.action <= ACT_STEP;
        cmd_ch.load_x <= '0;
        cmd_ch.load_y <= '0;
        cmd_ch.load_z <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset coefficients.
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_STEP, Q_MAX, Q_MIN, Q_MAX);
        send_cmd(ACT_UNUSED, $urandom, $urandom, $urandom);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, Q_MAX, Q_MAX, Q_MAX);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, Q_MIN, Q_MIN, Q_MIN);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, Q_MAX, Q_MIN, 32'd0);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, 32'd0, 32'd0, 32'd0);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_RESTART, Q_MAX, Q_MAX, Q_MAX);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, Q_MIN, Q_MAX, Q_MIN);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_LOAD, 32'd1, 32'hFFFF_FFFF, 32'd1);
        send_cmd(ACT_STEP, '0, '0, '0);
        send_cmd(ACT_UNUSED, Q_MAX, Q_MAX, Q_MAX);
        send_cmd(ACT_STEP, '0, '0, '0);
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase > 0)
                program_phase(phase);
            // One whole phase runs with both sides always willing.
            idle_pct <= (phase == 1) ? 0 : 16;
            // A step first shows that new start values leave the point alone.
            send_cmd(ACT_STEP, $urandom, $urandom, $urandom);
            send_cmd(ACT_RESTART, $urandom, $urandom, $urandom);
            run_random(PHASE_ITEMS);
            settle();
        end

        $display("Run covered %0d command items and %0d checked steps, %0d of them saturating,",
                 tracker.commands, tracker.checked, tracker.clip_steps);
        $display("over %0d register settings from reset values to full-scale and all-zero ones.",
                 PHASE_COUNT);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
